/* hdl/aldb_pkg.sv */
// ----------------------------------------------------------------------------
// aldb_pkg
// Shared types and constants of the ladder keypad decoder.
// ----------------------------------------------------------------------------
package aldb_pkg;

  localparam int ADC_BITS    = 12;
  localparam int TIME_BITS   = 48;
  localparam int LPT_BITS    = 32;
  localparam int NUM_BUTTONS = 4;
  localparam int BTN_BITS    = $clog2(NUM_BUTTONS);

  typedef logic [ADC_BITS-1:0]  level_t;
  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [LPT_BITS-1:0]  lpt_t;

  typedef enum logic [1:0] {
    EV_PRESS = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef enum logic [2:0] {
    REG_LEVEL_TOP    = 3'd0,
    REG_LEVEL_A_B    = 3'd1,
    REG_LEVEL_B_X    = 3'd2,
    REG_LEVEL_X_Y    = 3'd3,
    REG_LEVEL_BOTTOM = 3'd4,
    REG_LONG_TIME    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    level_t top;
    level_t a_b;
    level_t b_x;
    level_t x_y;
    level_t bottom;
    lpt_t   long_time;
  } cfg_t;

  // Result of decoding one sample against the current key state
  typedef struct packed {
    logic [NUM_BUTTONS-1:0]       ev_valid;
    logic [NUM_BUTTONS-1:0][1:0]  kind;
    logic [NUM_BUTTONS-1:0]       held;
    stamp_t                       press_time;
  } step_t;

endpackage

/* hdl/aldb_classify.sv */
// ----------------------------------------------------------------------------
// aldb_classify
// Window compare of one sample and per-button press/release decision.
// ----------------------------------------------------------------------------
module aldb_classify (
  input  aldb_pkg::cfg_t                       cfg,
  input  aldb_pkg::level_t                     sample,
  input  aldb_pkg::stamp_t                     timestamp,
  input  logic [aldb_pkg::NUM_BUTTONS-1:0]     held,
  input  aldb_pkg::stamp_t                     press_time,
  output aldb_pkg::step_t                      step
);

  aldb_pkg::level_t lo [aldb_pkg::NUM_BUTTONS];
  aldb_pkg::level_t hi [aldb_pkg::NUM_BUTTONS];
  aldb_pkg::stamp_t dt;
  logic             long_c;
  logic             pressed_earlier;
  logic             hit;

  always_comb begin
    hi[0] = cfg.top;  lo[0] = cfg.a_b;
    hi[1] = cfg.a_b;  lo[1] = cfg.b_x;
    hi[2] = cfg.b_x;  lo[2] = cfg.x_y;
    hi[3] = cfg.x_y;  lo[3] = cfg.bottom;
  end

  assign dt     = timestamp - press_time;
  assign long_c = 64'(dt) > 64'(cfg.long_time);

  always_comb begin
    step            = '0;
    step.press_time = press_time;
    pressed_earlier = 1'b0;
    hit             = 1'b0;
    for (int k = 0; k < aldb_pkg::NUM_BUTTONS; k++) begin
      hit = (lo[k] <= sample) && (sample <= hi[k]);
      step.held[k] = hit;
      if (hit && !held[k]) begin
        step.ev_valid[k] = 1'b1;
        step.kind[k]     = aldb_pkg::EV_PRESS;
        step.press_time  = timestamp;
        pressed_earlier  = 1'b1;
      end else if (!hit && held[k]) begin
        // an earlier press in this sample restarts the timer: elapsed is zero
        step.ev_valid[k] = 1'b1;
        step.kind[k]     = (long_c && !pressed_earlier) ? aldb_pkg::EV_LONG
                                                        : aldb_pkg::EV_SHORT;
      end
    end
  end

endmodule

/* hdl/adc_ladder_button_decoder.sv */
// ----------------------------------------------------------------------------
// adc_ladder_button_decoder
// Resistor-ladder keypad decoder: classifies ADC samples into four button
// windows and emits press, short release and long release events.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  in_      | sink      | tdata: sample[11:0], timestamp[59:12], zero pad
//  out_     | source    | tdata: button[1:0], pad; tuser: event_res; tlast
//  cfg_     | APB slave | six registers at byte address 4*index
//
//  A sample is taken into an input register, decoded there and its events
//  (0 to 4) loaded into the event register once that is empty or sending
//  its last event; the event register sends one event per cycle while
//  out_tready is high. Reset clears key state and press time and loads the
//  default levels. A stalled output holds the event register; the input
//  register accepts a new sample as long as it is empty or moving on.
// ----------------------------------------------------------------------------
module adc_ladder_button_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // sample[11:0], timestamp[59:12], zeros[63:60]
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // button[1:0], zeros[7:2]
  output logic [7:0]  out_tdata,
  // event_res[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NB = aldb_pkg::NUM_BUTTONS;

  aldb_pkg::cfg_t   cfg_r;
  logic             s1_valid_r;
  aldb_pkg::level_t s1_sample_r;
  aldb_pkg::stamp_t s1_stamp_r;
  logic [NB-1:0]    held_r;
  aldb_pkg::stamp_t press_time_r;
  logic [NB-1:0]    pend_r, pend_nxt;
  logic [NB-1:0][1:0] kind_r;

  aldb_pkg::step_t  step;
  aldb_pkg::reg_idx_t reg_idx;
  logic [NB-1:0]    sel_oh;
  logic [aldb_pkg::BTN_BITS-1:0] sel_idx;
  logic             bundle_free;
  logic             s1_move;
  logic             out_xfer;
  logic             cfg_wr;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = aldb_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top       <= aldb_pkg::ADC_BITS'(4095);
      cfg_r.a_b       <= aldb_pkg::ADC_BITS'(3072);
      cfg_r.b_x       <= aldb_pkg::ADC_BITS'(2048);
      cfg_r.x_y       <= aldb_pkg::ADC_BITS'(1024);
      cfg_r.bottom    <= aldb_pkg::ADC_BITS'(256);
      cfg_r.long_time <= aldb_pkg::LPT_BITS'(1000000);
    end else if (cfg_wr) begin
      case (reg_idx)
        aldb_pkg::REG_LEVEL_TOP:    cfg_r.top       <= cfg_pwdata[aldb_pkg::ADC_BITS-1:0];
        aldb_pkg::REG_LEVEL_A_B:    cfg_r.a_b       <= cfg_pwdata[aldb_pkg::ADC_BITS-1:0];
        aldb_pkg::REG_LEVEL_B_X:    cfg_r.b_x       <= cfg_pwdata[aldb_pkg::ADC_BITS-1:0];
        aldb_pkg::REG_LEVEL_X_Y:    cfg_r.x_y       <= cfg_pwdata[aldb_pkg::ADC_BITS-1:0];
        aldb_pkg::REG_LEVEL_BOTTOM: cfg_r.bottom    <= cfg_pwdata[aldb_pkg::ADC_BITS-1:0];
        aldb_pkg::REG_LONG_TIME:    cfg_r.long_time <= cfg_pwdata[aldb_pkg::LPT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aldb_pkg::REG_LEVEL_TOP:    cfg_prdata = 32'(cfg_r.top);
      aldb_pkg::REG_LEVEL_A_B:    cfg_prdata = 32'(cfg_r.a_b);
      aldb_pkg::REG_LEVEL_B_X:    cfg_prdata = 32'(cfg_r.b_x);
      aldb_pkg::REG_LEVEL_X_Y:    cfg_prdata = 32'(cfg_r.x_y);
      aldb_pkg::REG_LEVEL_BOTTOM: cfg_prdata = 32'(cfg_r.bottom);
      aldb_pkg::REG_LONG_TIME:    cfg_prdata = 32'(cfg_r.long_time);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------- event register / output ----------------
  assign sel_oh = pend_r & (~pend_r + NB'(1));

  always_comb begin
    sel_idx = '0;
    for (int k = 0; k < NB; k++) begin
      if (sel_oh[k]) sel_idx = aldb_pkg::BTN_BITS'(k);
    end
  end

  assign out_tvalid = |pend_r;
  assign out_tlast  = (pend_r & ~sel_oh) == '0;
  assign out_tdata  = 8'(sel_idx);
  assign out_tuser  = kind_r[sel_idx];
  assign out_xfer   = out_tvalid && out_tready;

  // take a new sample's events once the last pending event leaves
  assign bundle_free = (pend_r == '0) || (out_xfer && out_tlast);
  assign s1_move     = s1_valid_r && bundle_free;
  assign in_tready   = !s1_valid_r || bundle_free;

  always_comb begin
    pend_nxt = pend_r;
    if (s1_move) begin
      pend_nxt = step.ev_valid;
    end else if (out_xfer) begin
      pend_nxt = pend_r & ~sel_oh;
    end
  end

  // ---------------- decode ----------------
  aldb_classify u_classify (
    .cfg        (cfg_r),
    .sample     (s1_sample_r),
    .timestamp  (s1_stamp_r),
    .held       (held_r),
    .press_time (press_time_r),
    .step       (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pend_r       <= '0;
      held_r       <= '0;
      press_time_r <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      pend_r <= pend_nxt;
      if (s1_move) begin
        held_r       <= step.held;
        press_time_r <= step.press_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[aldb_pkg::ADC_BITS-1:0];
      s1_stamp_r  <= in_tdata[aldb_pkg::ADC_BITS +: aldb_pkg::TIME_BITS];
    end
    if (s1_move) kind_r <= step.kind;
  end

endmodule

/* tb/sv/aldb_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldb_event_checker
// Watches the sample, event and register ports of the ladder keypad decoder.
// Keeps its own copy of the levels, the key flags and the press time, works
// out the events of every accepted sample and compares each event transfer
// in order against them.
// ----------------------------------------------------------------------------
module aldb_event_checker
  import aldb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          mismatches
);

  typedef struct packed {
    logic [BTN_BITS-1:0] button;
    ev_t                 kind;
    logic                last;
  } key_event_t;

  key_event_t             events_due[$];
  key_event_t             due;
  cfg_t                   levels;
  logic [NUM_BUTTONS-1:0] key_held;
  stamp_t                 last_press;

  // Visit the buttons in order; a press moves the shared press time before
  // the later buttons look at it.
  function automatic void decode_sample(input level_t s, input stamp_t now);
    level_t     lo [NUM_BUTTONS];
    level_t     hi [NUM_BUTTONS];
    stamp_t     elapsed;
    key_event_t ev;
    int         first;
    first = events_due.size();
    hi[0] = levels.top;  lo[0] = levels.a_b;
    hi[1] = levels.a_b;  lo[1] = levels.b_x;
    hi[2] = levels.b_x;  lo[2] = levels.x_y;
    hi[3] = levels.x_y;  lo[3] = levels.bottom;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      ev.button = BTN_BITS'(k);
      ev.last   = 1'b0;
      if (s >= lo[k] && s <= hi[k]) begin
        if (!key_held[k]) begin
          last_press = now;
          ev.kind    = EV_PRESS;
          events_due.push_back(ev);
        end
        key_held[k] = 1'b1;
      end else begin
        if (key_held[k]) begin
          elapsed = now - last_press;
          ev.kind = (elapsed > stamp_t'(levels.long_time)) ? EV_LONG : EV_SHORT;
          events_due.push_back(ev);
        end
        key_held[k] = 1'b0;
      end
    end
    // mark the final event of this sample
    if (events_due.size() > first) begin
      ev      = events_due.pop_back();
      ev.last = 1'b1;
      events_due.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      levels.top       = ADC_BITS'(4095);
      levels.a_b       = ADC_BITS'(3072);
      levels.b_x       = ADC_BITS'(2048);
      levels.x_y       = ADC_BITS'(1024);
      levels.bottom    = ADC_BITS'(256);
      levels.long_time = LPT_BITS'(1000000);
      key_held         = '0;
      last_press       = '0;
      mismatches       = 0;
      events_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_LEVEL_TOP:    levels.top       = cfg_pwdata[ADC_BITS-1:0];
          REG_LEVEL_A_B:    levels.a_b       = cfg_pwdata[ADC_BITS-1:0];
          REG_LEVEL_B_X:    levels.b_x       = cfg_pwdata[ADC_BITS-1:0];
          REG_LEVEL_X_Y:    levels.x_y       = cfg_pwdata[ADC_BITS-1:0];
          REG_LEVEL_BOTTOM: levels.bottom    = cfg_pwdata[ADC_BITS-1:0];
          REG_LONG_TIME:    levels.long_time = cfg_pwdata[LPT_BITS-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event, expected none, got button %0d kind %0d last %0d",
                   $time, out_tdata[1:0], out_tuser, out_tlast);
          mismatches++;
        end else begin
          due = events_due.pop_front();
          if (out_tdata[BTN_BITS-1:0] !== due.button) begin
            $display("%0t: button mismatch, expected %0d, got %0d",
                     $time, due.button, out_tdata[BTN_BITS-1:0]);
            mismatches++;
          end
          if (out_tuser !== due.kind) begin
            $display("%0t: event kind mismatch, expected %0d, got %0d",
                     $time, due.kind, out_tuser);
            mismatches++;
          end
          if (out_tlast !== due.last) begin
            $display("%0t: last flag mismatch, expected %0d, got %0d",
                     $time, due.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        decode_sample(in_tdata[ADC_BITS-1:0], in_tdata[ADC_BITS +: TIME_BITS]);
    end
    pending <= events_due.size();
  end

endmodule

/* tb/sv/tb_adc_ladder_button_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_ladder_button_decoder
// Drives samples and register writes into the ladder keypad decoder: a
// directed pass over window boundaries, empty windows, release timing and
// time wrap, then random press/hold/release sequences under several level
// settings with random gaps and stalls. The checker beside the block does
// the comparison; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_adc_ladder_button_decoder;
  import aldb_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         LONG_HOLD    = 300;
  localparam int         NUM_PHASES   = 6;
  localparam int         PHASE_ITEMS  = 48;
  localparam logic [2:0] REG_SPARE    = 3'd6;  // no register behind this index

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic [63:0] in_tdata    = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          pending;
  int          mismatches;
  int          cycle_count = 0;
  bit          stall_now   = 1'b0;
  bit          quiet       = 1'b0;

  // levels as last written, index 0 top down to 4 bottom
  level_t      lv [5];
  lpt_t        lpt;
  stamp_t      now_ts;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adc_ladder_button_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  aldb_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .mismatches  (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_adc_ladder_button_decoder failed");
      $finish;
    end
  end

  // Event receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    bit stall_seen;
    stall_seen = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_now && !stall_seen) begin
        stall_seen = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LEVEL_TOP:    lv[0] = value[ADC_BITS-1:0];
      REG_LEVEL_A_B:    lv[1] = value[ADC_BITS-1:0];
      REG_LEVEL_B_X:    lv[2] = value[ADC_BITS-1:0];
      REG_LEVEL_X_Y:    lv[3] = value[ADC_BITS-1:0];
      REG_LEVEL_BOTTOM: lv[4] = value[ADC_BITS-1:0];
      REG_LONG_TIME:    lpt   = value;
      default: ;
    endcase
  endtask

  task automatic apply_levels(input level_t top, input level_t a_b, input level_t b_x,
                              input level_t x_y, input level_t bottom, input lpt_t long_time);
    cfg_write(REG_LEVEL_TOP, 32'(top));
    cfg_write(REG_LEVEL_A_B, 32'(a_b));
    cfg_write(REG_LEVEL_B_X, 32'(b_x));
    cfg_write(REG_LEVEL_X_Y, 32'(x_y));
    cfg_write(REG_LEVEL_BOTTOM, 32'(bottom));
    cfg_write(REG_LONG_TIME, long_time);
  endtask

  // Hold valid until the transfer; return at the edge that took it
  task automatic send_sample(input level_t s, input stamp_t ts);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, ts, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drain all events, then let any event-free sample leave the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic stamp_t next_stamp();
    case ($urandom_range(0, 5))
      0: now_ts = now_ts + stamp_t'($urandom_range(0, 3));
      1: now_ts = now_ts + stamp_t'(lpt);
      2: now_ts = now_ts + stamp_t'(lpt) + 1;
      3: now_ts = now_ts + stamp_t'($urandom_range(0, lpt));
      4: now_ts = now_ts + stamp_t'($urandom);
      default: now_ts = stamp_t'({$urandom, $urandom});
    endcase
    return now_ts;
  endfunction

  function automatic level_t pick_press();
    int k;
    if ($urandom_range(0, 3) == 0)
      return lv[$urandom_range(0, 4)];
    k = $urandom_range(0, 3);
    if (lv[k+1] <= lv[k])
      return level_t'($urandom_range(lv[k+1], lv[k]));
    return level_t'($urandom);
  endfunction

  // Outside every window where the levels leave room for it
  function automatic level_t pick_release();
    bit below_ok;
    bit above_ok;
    below_ok = lv[4] > 0;
    above_ok = lv[0] < {ADC_BITS{1'b1}};
    if (below_ok && (!above_ok || $urandom_range(0, 1) == 0))
      return level_t'($urandom_range(0, lv[4] - 1));
    if (above_ok)
      return level_t'($urandom_range(lv[0] + 1, {ADC_BITS{1'b1}}));
    return level_t'($urandom);
  endfunction

  task automatic run_random(input int count);
    int     sent;
    int     reps;
    level_t s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_sample(level_t'($urandom), next_stamp());
        sent++;
      end else begin
        s    = pick_press();
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          send_sample(s, next_stamp());
          sent++;
        end
        send_sample(pick_release(), next_stamp());
        sent++;
      end
    end
  endtask

  initial begin
    level_t t, a, b, x, y;
    lv     = '{12'd4095, 12'd3072, 12'd2048, 12'd1024, 12'd256};
    lpt    = 32'd1000000;
    now_ts = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, walk the ladder across every shared boundary
    send_sample(12'd0,    48'd0);
    send_sample(12'd4095, 48'd10);
    send_sample(12'd3072, 48'd20);
    send_sample(12'd2048, 48'd30);
    send_sample(12'd1024, 48'd40);
    send_sample(12'd256,  48'd50);
    // release past the long-press interval, then press again and release one past it
    send_sample(12'd255,  48'd1000050);
    send_sample(12'd300,  48'd1000100);
    send_sample(12'd255,  48'd2000101);
    // elapsed time across the timestamp wrap
    send_sample(12'd4095, 48'hFFFF_FFFF_FFF0);
    send_sample(12'd0,    48'h0000_0000_0005);
    send_sample(12'd2000, 48'hFFFF_FFFF_FFFF);
    send_sample(12'd0,    48'h0000_0000_0000);
    // earlier press resets the time seen by a later release
    send_sample(12'd2500, 48'd10000000);
    send_sample(12'd2500, 48'd10000001);
    send_sample(12'd4000, 48'd20000000);
    send_sample(12'd4000, 48'd40000000);
    send_sample(12'd0,    48'd40000000);
    settle();

    // Directed: empty A and X windows, Y spans the range, zero interval
    apply_levels(12'd100, 12'd200, 12'd50, 12'd4095, 12'd0, 32'd0);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    send_sample(12'd150,  48'd100);
    send_sample(12'd150,  48'd101);
    send_sample(12'd10,   48'd102);
    send_sample(12'd4095, 48'd103);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_levels(12'd4095, 12'd3072, 12'd2048, 12'd1024, 12'd256, 32'd1000000);
        1: apply_levels(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0);
        2: apply_levels(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        4: apply_levels(level_t'($urandom), level_t'($urandom), level_t'($urandom),
                        level_t'($urandom), level_t'($urandom), lpt_t'($urandom));
        default: begin
          t = level_t'($urandom_range(2048, 4095));
          a = level_t'($urandom_range(1536, t));
          b = level_t'($urandom_range(1024, a));
          x = level_t'($urandom_range(256, b));
          y = level_t'($urandom_range(0, x));
          apply_levels(t, a, b, x, y, lpt_t'($urandom_range(0, 20000)));
        end
      endcase
      if (ph == 2)
        stall_now <= 1'b1;
      if (ph == NUM_PHASES - 1)
        quiet <= 1'b1;
      run_random(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb_adc_ladder_button_decoder passed");
    end else begin
      $display("tb_adc_ladder_button_decoder failed");
    end
    $finish;
  end

endmodule
